@@ rtl/mpcc_pkg.sv @@
package mpcc_pkg;

    localparam int ScreenW = 320;
    localparam int ScreenH = 240;

    // Reciprocals for the coordinate scaling, exact for every 9-bit x and 8-bit y:
    // floor(x*65536/ScreenW) = (x*RECIP_W) >> 12, floor(y*65536/ScreenH) = (y*RECIP_H) >> 12.
    localparam logic [19:0] RECIP_W = 20'd838861;
    localparam logic [20:0] RECIP_H = 21'd1118482;

    // Angle multipliers, 16 fraction bits.
    localparam logic [23:0] K3   = 24'd8010531;
    localparam logic [23:0] K25  = 24'd6675442;
    localparam logic [23:0] K2   = 24'd5340354;
    localparam logic [23:0] K35  = 24'd9345619;
    localparam logic [23:0] K28  = 24'd7476495;
    localparam logic [19:0] PH_ROT = 20'd240316;
    localparam logic [19:0] PH_T1  = 20'd720948;
    localparam logic [19:0] PH_T2  = 20'd600790;
    localparam logic [19:0] PH_PAT = 20'd841106;
    localparam logic [12:0] TURB_GAIN = 13'd5243;

    localparam logic [23:0] BASE_RESET   = 24'h19191C;
    localparam logic [23:0] ACCENT_RESET = 24'h6E2D37;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_ACCENT = 2'd1;
    localparam logic [1:0] REG_PHASE  = 2'd2;

    // Quarter-wave sine magnitude, unsigned 1.8.
    function automatic logic [8:0] quarter(input logic [6:0] m);
        logic [8:0] q [0:64];
        q = '{9'd0, 9'd6, 9'd12, 9'd18, 9'd25, 9'd31, 9'd37, 9'd43, 9'd49, 9'd56,
              9'd62, 9'd68, 9'd74, 9'd80, 9'd86, 9'd92, 9'd97, 9'd103, 9'd109,
              9'd115, 9'd120, 9'd126, 9'd131, 9'd136, 9'd142, 9'd147, 9'd152,
              9'd157, 9'd162, 9'd167, 9'd171, 9'd176, 9'd181, 9'd185, 9'd189,
              9'd193, 9'd197, 9'd201, 9'd205, 9'd209, 9'd212, 9'd216, 9'd219,
              9'd222, 9'd225, 9'd228, 9'd231, 9'd234, 9'd236, 9'd238, 9'd241,
              9'd243, 9'd244, 9'd246, 9'd248, 9'd249, 9'd251, 9'd252, 9'd253,
              9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd256};
        return (m <= 7'd64) ? q[m] : 9'd0;
    endfunction

    // Sine table lookup: 256 steps per turn, signed 2.8 result.
    function automatic logic signed [9:0] sin_lut(input logic [7:0] idx);
        logic [6:0] k;
        logic [6:0] m;
        logic [8:0] v;
        k = idx[6:0];
        m = (k <= 7'd64) ? k : 7'(8'd128 - {1'b0, k});
        v = quarter(m);
        return idx[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

@@ rtl/marble_pattern_cell_color_top.sv @@
// Marble pattern cell color generator.
// Input stream: s_axis_tdata carries one cell coordinate per transaction.
// Output stream: m_axis_tdata carries the echoed coordinate and the blended
// RGB color of that cell, one result transaction per input transaction.
// Configuration: APB registers base_color (0x0), accent_color (0x4) and
// phase (0x8); write them only while the pipeline is empty.
// Throughput is one cell per clock while the receiver does not stall; every one
// of the ten register stages takes a new item each cycle, and each stage holds
// about one multiply or one table lookup.
// The whole pipeline advances only while the output register is free or
// being drained, so when the receiver stalls every stage holds its item and
// s_axis_tready falls; nothing is lost or repeated.
// Reset clears all valid bits and loads the color and phase registers with
// their defaults.
module marble_pattern_cell_color_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // cell_x[8:0], cell_y[16:9], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_x[8:0], out_y[16:9], red[24:17],
                                       // green[32:25], blue[40:33], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mpcc_pkg::*;

    localparam int NS = 10;

    logic [23:0] base_reg, accent_reg;
    logic [31:0] phase_reg;
    logic [NS-1:0] vld_reg;
    logic adv;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            accent_reg <= ACCENT_RESET;
            phase_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3:2] == REG_BASE)   base_reg   <= pwdata[23:0];
            if (paddr[3:2] == REG_ACCENT) accent_reg <= pwdata[23:0];
            if (paddr[3:2] == REG_PHASE)  phase_reg  <= pwdata;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE:   prdata = {8'd0, base_reg};
            REG_ACCENT: prdata = {8'd0, accent_reg};
            REG_PHASE:  prdata = phase_reg;
            default:    prdata = '0;
        endcase
    end

    // Phase-derived terms only depend on configuration.
    logic [51:0] ph_rot_p, ph_t1_p, ph_t2_p, ph_pat_p;
    assign ph_rot_p = phase_reg * PH_ROT;
    assign ph_t1_p  = phase_reg * PH_T1;
    assign ph_t2_p  = phase_reg * PH_T2;
    assign ph_pat_p = phase_reg * PH_PAT;

    // Global stall control.
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
    end

    // Coordinates travel alongside.
    logic [8:0] cx_reg [NS];
    logic [7:0] cy_reg [NS];

    // Stage registers.
    logic [16:0] px1_reg, py1_reg;
    logic [16:0] px2_reg, py2_reg;
    logic [7:0]  pyi2_reg;
    logic [16:0] px3_reg, py3_reg;
    logic signed [16:0] rsin3_reg;
    logic [7:0]  rot4_reg;
    logic [16:0] px4_reg, py4_reg;
    logic signed [27:0] a5_reg, b5_reg, c5_reg, d5_reg;
    logic signed [19:0] nx6_reg, ny6_reg;
    logic [7:0] t1i7_reg, t2i7_reg;
    logic signed [19:0] nx7_reg, ny7_reg;
    logic signed [19:0] nx8_reg, ny8_reg;
    logic [7:0] pati_reg;
    logic [23:0] rgb_reg;

    // Combinational next values.
    logic [16:0] px_n, py_n;
    logic [40:0] pyk3;
    logic signed [16:0] rsin_n;
    logic [7:0] rot_n;
    logic signed [9:0] c_v, s_v;
    logic signed [44:0] t1_full, t2_full;
    logic signed [31:0] t1_s, t2_s;
    logic signed [22:0] tb1, tb2;
    logic signed [19:0] nx8_n, ny8_n;
    logic signed [44:0] pa, pb;
    logic signed [31:0] pat_s;
    logic signed [10:0] wsin;
    logic [16:0] w;
    logic [23:0] rgb_n;

    // Coordinate scaling by reciprocal multiplication.
    logic [28:0] px_prod, py_prod;
    assign px_prod = s_axis_tdata[8:0] * RECIP_W;
    assign py_prod = s_axis_tdata[16:9] * RECIP_H;
    assign px_n = px_prod[28:12];
    assign py_n = py_prod[28:12];
    assign pyk3 = py1_reg * K3;

    always_comb
    begin
        logic signed [16:0] sp;
        sp = 17'(sin_lut(pyi2_reg)) * 17'sd77;
        rsin_n = sp >>> 8;
        rot_n = 8'(ph_rot_p[39:32] + 8'(rsin3_reg));
        c_v = sin_lut(8'(rot4_reg + 8'd64));
        s_v = sin_lut(rot4_reg);
    end

    always_comb
    begin
        logic signed [28:0] sx6, sy6;
        sx6 = 29'(a5_reg) - 29'(b5_reg);
        sy6 = 29'(c5_reg) + 29'(d5_reg);
        nx8_n = 20'(sx6 >>> 8);
        ny8_n = 20'(sy6 >>> 8);
    end

    assign t1_full = ny6_reg * $signed({1'b0, K25});
    assign t2_full = nx6_reg * $signed({1'b0, K2});
    assign t1_s = 32'(t1_full >>> 16) + 32'(ph_t1_p[47:16]);
    assign t2_s = 32'(t2_full >>> 16) + 32'(ph_t2_p[47:16]);
    assign tb1 = (23'(sin_lut(t1i7_reg)) * $signed({1'b0, TURB_GAIN})) >>> 8;
    assign tb2 = (23'(sin_lut(8'(t2i7_reg + 8'd64))) * $signed({1'b0, TURB_GAIN})) >>> 8;
    assign pa = nx8_reg * $signed({1'b0, K35});
    assign pb = ny8_reg * $signed({1'b0, K28});
    assign pat_s = 32'(pa >>> 16) + 32'(pb >>> 16) + 32'(ph_pat_p[47:16]);
    assign wsin = 11'(sin_lut(pati_reg));
    assign w = 17'(32'sd32768 + 32'(wsin) * 32'sd128);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [8:0] bb, aa, dm;
            logic [25:0] pr;
            logic [7:0] t;
            bb = {1'b0, base_reg[8*i +: 8]};
            aa = {1'b0, accent_reg[8*i +: 8]};
            dm = (aa >= bb) ? aa - bb : bb - aa;
            pr = dm * w;
            t = pr[23:16];
            rgb_n[8*i +: 8] = (aa >= bb) ? bb[7:0] + t : bb[7:0] - t;
        end
    end

    // Pipeline registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= s_axis_tdata[8:0];
            cy_reg[0] <= s_axis_tdata[16:9];
            for (int i = 1; i < NS; i++)
            begin
                cx_reg[i] <= cx_reg[i-1];
                cy_reg[i] <= cy_reg[i-1];
            end
            px1_reg <= px_n;            py1_reg <= py_n;
            px2_reg <= px1_reg;         py2_reg <= py1_reg;
            pyi2_reg <= pyk3[39:32];
            px3_reg <= px2_reg;         py3_reg <= py2_reg;
            rsin3_reg <= rsin_n;
            px4_reg <= px3_reg;         py4_reg <= py3_reg;
            rot4_reg <= rot_n;
            a5_reg <= $signed({1'b0, px4_reg}) * c_v;
            b5_reg <= $signed({1'b0, py4_reg}) * s_v;
            c5_reg <= $signed({1'b0, px4_reg}) * s_v;
            d5_reg <= $signed({1'b0, py4_reg}) * c_v;
            nx6_reg <= nx8_n;           ny6_reg <= ny8_n;
            t1i7_reg <= t1_s[23:16];    t2i7_reg <= t2_s[23:16];
            nx7_reg <= nx6_reg;         ny7_reg <= ny6_reg;
            nx8_reg <= nx7_reg + 20'(tb1);
            ny8_reg <= ny7_reg + 20'(tb2);
            pati_reg <= pat_s[23:16];
            rgb_reg <= rgb_n;
        end
    end

    assign m_axis_tdata = {7'd0, rgb_reg[7:0], rgb_reg[15:8], rgb_reg[23:16],
                           cy_reg[NS-1], cx_reg[NS-1]};

endmodule

@@ test/testbench.sv @@
module testbench;
    import mpcc_pkg::*;

    typedef struct packed {
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cell_color_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the color and phase registers.
    logic [23:0] base_q;
    logic [23:0] accent_q;
    logic [31:0] phase_q;

    cell_color_t color_queue[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    localparam int CycleLimit = 400000;

    marble_pattern_cell_color_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Table sine with 256 steps per turn, index taken mod 256.
    function automatic longint sine_at(input longint idx);
        logic [7:0] k;
        int         m;
        int         v;
        logic [8:0] q [0:64];
        q = '{9'd0, 9'd6, 9'd12, 9'd18, 9'd25, 9'd31, 9'd37, 9'd43, 9'd49, 9'd56,
              9'd62, 9'd68, 9'd74, 9'd80, 9'd86, 9'd92, 9'd97, 9'd103, 9'd109,
              9'd115, 9'd120, 9'd126, 9'd131, 9'd136, 9'd142, 9'd147, 9'd152,
              9'd157, 9'd162, 9'd167, 9'd171, 9'd176, 9'd181, 9'd185, 9'd189,
              9'd193, 9'd197, 9'd201, 9'd205, 9'd209, 9'd212, 9'd216, 9'd219,
              9'd222, 9'd225, 9'd228, 9'd231, 9'd234, 9'd236, 9'd238, 9'd241,
              9'd243, 9'd244, 9'd246, 9'd248, 9'd249, 9'd251, 9'd252, 9'd253,
              9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd256};
        k = idx[7:0];
        m = (k[6:0] <= 64) ? k[6:0] : 128 - k[6:0];
        v = q[m];
        return k[7] ? -v : v;
    endfunction

    // Arithmetic right shift is a floor for signed values.
    function automatic longint floor_sh(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint angle_of(input longint a);
        return (a >>> 16) & 255;
    endfunction

    function automatic logic [7:0] blend_channel(input logic [7:0] b, input logic [7:0] a,
                                                 input longint w);
        longint d;
        longint t;
        d = longint'(a) - longint'(b);
        t = (d >= 0) ? ((d * w) >>> 16) : -(((-d) * w) >>> 16);
        return 8'(longint'(b) + t);
    endfunction

    function automatic cell_color_t marble_color(input logic [8:0] cx, input logic [7:0] cy);
        longint      px, py, rot, c, s, nx, ny, t1, t2, pat, w, ph;
        cell_color_t r;
        ph = longint'(phase_q);
        px = (longint'(cx) << 16) / ScreenW;
        py = (longint'(cy) << 16) / ScreenH;
        rot = ((ph * longint'(PH_ROT)) >> 32)
            + floor_sh(sine_at(floor_sh(py * longint'(K3), 32)) * 77, 8);
        c = sine_at(rot + 64);
        s = sine_at(rot);
        nx = floor_sh(px * c - py * s, 8);
        ny = floor_sh(px * s + py * c, 8);
        t1 = floor_sh(ny * longint'(K25), 16) + ((ph * longint'(PH_T1)) >> 16);
        t2 = floor_sh(nx * longint'(K2), 16) + ((ph * longint'(PH_T2)) >> 16);
        nx += floor_sh(sine_at(angle_of(t1)) * longint'(TURB_GAIN), 8);
        ny += floor_sh(sine_at(angle_of(t2) + 64) * longint'(TURB_GAIN), 8);
        pat = floor_sh(nx * longint'(K35), 16) + floor_sh(ny * longint'(K28), 16)
            + ((ph * longint'(PH_PAT)) >> 16);
        w = 32768 + 128 * sine_at(angle_of(pat));
        r.x = cx;
        r.y = cy;
        r.red = blend_channel(base_q[23:16], accent_q[23:16], w);
        r.green = blend_channel(base_q[15:8], accent_q[15:8], w);
        r.blue = blend_channel(base_q[7:0], accent_q[7:0], w);
        return r;
    endfunction

    // Register write over APB: setup then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASE:   base_q = value[23:0];
            REG_ACCENT: accent_q = value[23:0];
            default:    phase_q = value;
        endcase
    endtask

    // Stop sending and wait for the pipeline to drain before touching registers.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (color_queue.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_colors(input logic [23:0] b, input logic [23:0] a,
                              input logic [31:0] ph);
        wait_drained();
        write_reg(REG_BASE, {8'd0, b});
        write_reg(REG_ACCENT, {8'd0, a});
        write_reg(REG_PHASE, ph);
    endtask

    // Send one cell transaction, with an optional random idle gap first.
    // The valid line stays high after acceptance so that cells can follow back to back.
    task automatic send_cell(input logic [8:0] cx, input logic [7:0] cy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, cy, cx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        color_queue.push_back(marble_color(cx, cy));
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        cell_color_t got;
        cell_color_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x = m_axis_tdata[8:0];
            got.y = m_axis_tdata[16:9];
            got.red = m_axis_tdata[24:17];
            got.green = m_axis_tdata[32:25];
            got.blue = m_axis_tdata[40:33];
            if (color_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = color_queue.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    // Run-length watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed();
        set_colors(24'h000000, 24'hFFFFFF, 32'd0);
        send_cell(9'd0, 8'd0);
        send_cell(9'd319, 8'd239);
        send_cell(9'd511, 8'd255);
        send_cell(9'd319, 8'd0);
        send_cell(9'd0, 8'd239);
        send_cell(9'd160, 8'd120);
        set_colors(24'hFFFFFF, 24'h000000, 32'hFFFFFFFF);
        send_cell(9'd0, 8'd0);
        send_cell(9'd511, 8'd255);
        send_cell(9'd100, 8'd200);
        send_cell(9'd319, 8'd239);
        set_colors(24'hFF00FF, 24'h00FF00, 32'h80000000);
        send_cell(9'd1, 8'd1);
        send_cell(9'd256, 8'd128);
        send_cell(9'd255, 8'd127);
        send_cell(9'd319, 8'd239);
    endtask

    task automatic test_random(input int count);
        logic [8:0] cx;
        logic [7:0] cy;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                cx = 9'($urandom);
                cy = 8'($urandom);
            end
            else
            begin
                cx = 9'($urandom_range(319));
                cy = 8'($urandom_range(239));
            end
            send_cell(cx, cy);
        end
    endtask

    task automatic test_phase(input int sidle, input int rstall, input int count);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        set_colors(24'($urandom), 24'($urandom), $urandom);
        test_random(count / 2);
        // Hold off until all results are back, then continue.
        wait_drained();
        test_random(count - count / 2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        base_q = BASE_RESET;
        accent_q = ACCENT_RESET;
        phase_q = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first.
        send_cell(9'd37, 8'd91);
        send_cell(9'd300, 8'd10);
        test_directed();
        test_phase(0, 0, 450);
        test_phase(74, 0, 400);
        test_phase(0, 74, 400);
        test_phase(17, 17, 450);
        set_colors(24'h000000, 24'h000000, 32'h0);
        test_random(30);
        set_colors(24'hFFFFFF, 24'hFFFFFF, 32'hFFFF0000);
        test_random(30);

        wait_drained();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
